[rtl/lfg_pkg.sv]
// ----------------------------------------------------------------------------
// lfg_pkg
// Shared constants, action codes and the request/response structs between the
// item controller and the lag-table core.
// ----------------------------------------------------------------------------
package lfg_pkg;

  // Lag table geometry
  localparam int STATE_SIZE = 55;
  localparam int ADDR_W     = $clog2(STATE_SIZE);
  localparam int WORD_W     = 30;
  localparam int DRAW_SHIFT = 6;
  localparam int DRAW_W     = WORD_W - DRAW_SHIFT;
  localparam int PARTNER_INIT = STATE_SIZE - STATE_SIZE / 2;

  // Item fields
  localparam int BOUND_W = 24;
  localparam int VALUE_W = 25;
  localparam int COUNT_W = 8;
  localparam int FACES_W = 16;
  localparam int MAX_DICE = 255;

  // Rejection retry cap per drawn value (range or dice)
  localparam int RETRY_CAP = 65536;
  localparam int TRY_W     = $clog2(RETRY_CAP + 1);

  typedef enum logic [1:0] {
    ACT_RANGE  = 2'd0,
    ACT_DICE   = 2'd1,
    ACT_RAW    = 2'd2,
    ACT_RESEED = 2'd3
  } action_t;

  // Controller to core
  typedef struct packed {
    logic              draw;
    logic              fill;
    logic [WORD_W-1:0] seed;
  } lfg_req_t;

  // Core to controller
  typedef struct packed {
    logic              idle;
    logic              done;
    logic [DRAW_W-1:0] value;
  } lfg_rsp_t;

endpackage

[rtl/lagged_fibonacci_rng_engine.sv]
// ----------------------------------------------------------------------------
// lagged_fibonacci_rng_engine
// Additive lagged-Fibonacci generator with range, dice, raw and reseed items.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_valid/in_ready) carry an action and its operands; each
//   item gives exactly one result item on out_valid/out_ready.
//   The seed is written on cfg_valid/cfg_ready (always ready) and is used by
//   the next reseed item. Write it only while the block is idle.
//   Each table draw is a request, then two reads of the single-read-port
//   table RAM and a write-back.
//   Raw draw: the result follows a single table draw. Range and dice: the
//   result follows a prepare step and one table draw per try (rejected draws
//   retried, on average under 2 draws per value); special cases that draw
//   nothing give their result after the prepare step.
//   Reseed: the result is 0; the table is refilled from the seed, and no
//   item is accepted during the refill.
//   After reset the table is filled from seed 0 with in_ready low.
//   One item is worked on at a time; a finished result waits in the
//   output register while out_ready is low, and the next item is accepted
//   only once the previous result has reached that register.
// ----------------------------------------------------------------------------
module lagged_fibonacci_rng_engine
  import lfg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic signed [BOUND_W-1:0] in_range_low,
  input  logic signed [BOUND_W-1:0] in_range_high,
  input  logic [COUNT_W-1:0]        in_dice_count,
  input  logic [FACES_W-1:0]        in_die_faces,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [WORD_W-1:0]         cfg_seed
);

  logic [WORD_W-1:0] seed_r;
  lfg_req_t          req;
  lfg_rsp_t          rsp;

  // Seed register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_seed;
    end
  end

  lfg_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (action_t'(in_action)),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .in_dice_count (in_dice_count),
    .in_die_faces  (in_die_faces),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .seed          (seed_r),
    .req           (req),
    .rsp           (rsp)
  );

  lfg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

endmodule

[rtl/lfg_ram.sv]
// ----------------------------------------------------------------------------
// lfg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lfg_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 55
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lfg_core.sv]
// ----------------------------------------------------------------------------
// lfg_core
// Lag table, its two circulating pointers and the seed fill sequencer.
// A draw reads the write word, then the partner word, then writes the sum.
// ----------------------------------------------------------------------------
module lfg_core
  import lfg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  lfg_req_t req,
  output lfg_rsp_t rsp
);

  typedef enum logic [2:0] {
    C_FILL,
    C_IDLE,
    C_RD_A,
    C_RD_B,
    C_SUM
  } core_state_t;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(STATE_SIZE - 1);
  localparam logic [ADDR_W-1:0] PP_INIT  = ADDR_W'(PARTNER_INIT);

  core_state_t       state_r;
  logic [ADDR_W-1:0] wp_r;
  logic [ADDR_W-1:0] pp_r;
  logic [ADDR_W-1:0] fill_idx_r;
  logic [WORD_W-1:0] p1_r;
  logic [WORD_W-1:0] p2_r;
  logic [WORD_W-1:0] word_a_r;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] fill_word;
  logic [WORD_W-1:0] sum;

  function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  lfg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Fill recurrence: seed, one, then sum of the two previous words
  always_comb begin
    if (fill_idx_r == '0) begin
      fill_word = p1_r;
    end else if (fill_idx_r == ADDR_W'(1)) begin
      fill_word = WORD_W'(1);
    end else begin
      fill_word = p1_r + p2_r;
    end
  end

  assign sum = word_a_r + rdata;

  // Table port control
  always_comb begin
    we    = 1'b0;
    waddr = wp_r;
    wdata = sum;
    raddr = wp_r;
    case (state_r)
      C_FILL: begin
        we    = 1'b1;
        waddr = fill_idx_r;
        wdata = fill_word;
      end
      C_RD_B: begin
        raddr = pp_r;
      end
      C_SUM: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign rsp.idle  = (state_r == C_IDLE);
  assign rsp.done  = (state_r == C_SUM);
  assign rsp.value = sum[WORD_W-1:DRAW_SHIFT];

  // Sequencer, pointers and fill history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= C_FILL;
      fill_idx_r <= '0;
      p1_r       <= '0;
      p2_r       <= '0;
      wp_r       <= '0;
      pp_r       <= PP_INIT;
    end else begin
      case (state_r)
        C_FILL: begin
          if (fill_idx_r != '0) begin
            p2_r <= p1_r;
            p1_r <= fill_word;
          end
          if (fill_idx_r == LAST_IDX) begin
            wp_r    <= '0;
            pp_r    <= PP_INIT;
            state_r <= C_IDLE;
          end else begin
            fill_idx_r <= fill_idx_r + 1'b1;
          end
        end
        C_IDLE: begin
          if (req.fill) begin
            fill_idx_r <= '0;
            p1_r       <= req.seed;
            state_r    <= C_FILL;
          end else if (req.draw) begin
            state_r <= C_RD_A;
          end
        end
        C_RD_A: begin
          state_r <= C_RD_B;
        end
        C_RD_B: begin
          word_a_r <= rdata;
          state_r  <= C_SUM;
        end
        C_SUM: begin
          wp_r    <= advance(wp_r);
          pp_r    <= advance(pp_r);
          state_r <= C_IDLE;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/lfg_ctrl.sv]
// ----------------------------------------------------------------------------
// lfg_ctrl
// Item controller: decodes the action, runs the masked rejection loop and the
// dice loop on top of core draws, and holds the output register.
// ----------------------------------------------------------------------------
module lfg_ctrl
  import lfg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  action_t                   in_action,
  input  logic signed [BOUND_W-1:0] in_range_low,
  input  logic signed [BOUND_W-1:0] in_range_high,
  input  logic [COUNT_W-1:0]        in_dice_count,
  input  logic [FACES_W-1:0]        in_die_faces,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_value,
  input  logic [WORD_W-1:0]         seed,
  output lfg_req_t                  req,
  input  lfg_rsp_t                  rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_REQ,
    S_WAIT,
    S_DONE
  } ctrl_state_t;

  localparam int SPAN_W = BOUND_W + 2;

  ctrl_state_t               state_r;
  action_t                   action_r;
  logic signed [BOUND_W-1:0] lo_r;
  logic signed [BOUND_W-1:0] hi_r;
  logic [COUNT_W-1:0]        count_r;
  logic [FACES_W-1:0]        faces_r;
  logic [VALUE_W-1:0]        span_r;
  logic [DRAW_W-1:0]         mask_r;
  logic signed [VALUE_W-1:0] base_r;
  logic [TRY_W-1:0]          tries_r;
  logic [COUNT_W-1:0]        left_r;
  logic signed [VALUE_W-1:0] acc_r;
  logic signed [VALUE_W-1:0] res_r;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;

  logic                      accept;
  logic [COUNT_W-1:0]        count_sat;
  logic signed [SPAN_W-1:0]  range_span;
  logic [SPAN_W-1:0]         prep_span;
  logic [SPAN_W-1:0]         prep_span_m1;
  logic [DRAW_W-1:0]         r;
  logic                      hit;
  logic                      draw_over;
  logic signed [VALUE_W-1:0] pick;
  logic signed [VALUE_W-1:0] acc_nxt;

  // Fold every set bit down to give the all-ones mask covering x
  function automatic logic [DRAW_W-1:0] smear(input logic [DRAW_W-1:0] x);
    logic [DRAW_W-1:0] y;
    y = x;
    y = y | (y >> 1);
    y = y | (y >> 2);
    y = y | (y >> 4);
    y = y | (y >> 8);
    y = y | (y >> 16);
    return y;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && rsp.idle;

  assign req.draw = (state_r == S_REQ) && rsp.idle;
  assign req.fill = accept && (in_action == ACT_RESEED);
  assign req.seed = seed;

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  assign count_sat = (count_r > COUNT_W'(MAX_DICE)) ? COUNT_W'(MAX_DICE) : count_r;

  // Span of the request: range bounds or dice faces
  assign range_span = SPAN_W'(hi_r) - SPAN_W'(lo_r) + SPAN_W'(1);
  assign prep_span  = (action_r == ACT_DICE) ? SPAN_W'(faces_r) : range_span;
  assign prep_span_m1 = prep_span - SPAN_W'(1);

  // Judge a finished draw against the span
  assign r         = rsp.value & mask_r;
  assign hit       = {1'b0, r} < span_r;
  assign draw_over = hit || (tries_r == TRY_W'(RETRY_CAP));
  assign pick      = hit ? (base_r + VALUE_W'(r)) : base_r;
  assign acc_nxt   = acc_r + pick;

  // Item sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken item unless a new one is loaded in its place
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            action_r <= in_action;
            lo_r     <= in_range_low;
            hi_r     <= in_range_high;
            count_r  <= in_dice_count;
            faces_r  <= in_die_faces;
            if (in_action == ACT_RESEED) begin
              res_r   <= '0;
              state_r <= S_DONE;
            end else if (in_action == ACT_RAW) begin
              state_r <= S_REQ;
            end else begin
              state_r <= S_PREP;
            end
          end
        end
        S_PREP: begin
          span_r  <= prep_span[VALUE_W-1:0];
          mask_r  <= smear(prep_span_m1[DRAW_W-1:0]);
          tries_r <= '0;
          acc_r   <= '0;
          left_r  <= count_sat;
          if (action_r == ACT_DICE) begin
            base_r <= VALUE_W'(1);
            if (faces_r == '0 || count_sat == '0) begin
              res_r   <= '0;
              state_r <= S_DONE;
            end else if (faces_r == FACES_W'(1)) begin
              res_r   <= VALUE_W'(count_sat);
              state_r <= S_DONE;
            end else begin
              state_r <= S_REQ;
            end
          end else begin
            base_r <= VALUE_W'(lo_r);
            if (lo_r == '0 && hi_r == '0) begin
              res_r   <= '0;
              state_r <= S_DONE;
            end else if (range_span <= SPAN_W'(1)) begin
              res_r   <= VALUE_W'(lo_r);
              state_r <= S_DONE;
            end else begin
              state_r <= S_REQ;
            end
          end
        end
        S_REQ: begin
          if (rsp.idle) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (rsp.done) begin
            if (action_r == ACT_RAW) begin
              res_r   <= VALUE_W'(rsp.value);
              state_r <= S_DONE;
            end else if (!draw_over) begin
              tries_r <= tries_r + 1'b1;
              state_r <= S_REQ;
            end else if (action_r == ACT_RANGE) begin
              res_r   <= pick;
              state_r <= S_DONE;
            end else if (left_r == COUNT_W'(1)) begin
              res_r   <= acc_nxt;
              state_r <= S_DONE;
            end else begin
              acc_r   <= acc_nxt;
              left_r  <= left_r - 1'b1;
              tries_r <= '0;
              state_r <= S_REQ;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
